>>> rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, widths and codes of the point-to-box distance classifier.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int COORD_BITS     = 32;
    localparam int GAP_BITS       = 33;
    localparam int MARGIN_BITS    = 31;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_BOTTOM = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_TOP    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN     = 3'd4;

    // point class codes
    localparam logic [1:0] CLS_OUTSIDE = 2'd0;
    localparam logic [1:0] CLS_EDGE    = 2'd1;
    localparam logic [1:0] CLS_INSIDE  = 2'd2;
    localparam logic [1:0] CLS_INDET   = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // reset box is inverted, so it starts out invalid
    localparam t_coord BOX_MIN_RESET = COORD_BITS'(64'sd2147483647);
    localparam t_coord BOX_MAX_RESET = COORD_BITS'(-64'sd2147483647);

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
    } t_point;

    typedef struct packed {
        logic [GAP_BITS-1:0] gap_length;
        logic [1:0]          point_class;
        logic                on_or_inside;
        logic                near_box;
    } t_result;

    // flags settled in the front, carried alongside the distance work
    typedef struct packed {
        logic [1:0] cls;
        logic       on_in;
        logic       near;
    } t_side;

    typedef struct packed {
        logic [COORD_BITS-1:0] gap_x;
        logic [COORD_BITS-1:0] gap_y;
        t_side                 side;
    } t_job;

endpackage

>>> rtl/point_box_distance_classify.sv
// ----------------------------------------------------------------------------
// point_box_distance_classify
// Distance from a query point to a configured axis-aligned box, with class,
// on-or-inside and grown-box proximity flags.
// ----------------------------------------------------------------------------
// One point is taken per cycle while busy is low, and one result leaves per
// cycle. Each result is shown on o_result for a single cycle with o_strobe
// high; the receiver has no way to hold results, so it must take every strobe.
// A point passes through the point register, the job queue, the squaring
// stage, the radicand register, the square root pipeline (one root bit per
// stage) and the result register. busy rises only while the job queue is
// full, which the back end never lets happen in steady flow. Write the box
// registers only when no result is outstanding.
// ----------------------------------------------------------------------------
module point_box_distance_classify #(
    parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pbd_pkg::t_point                    i_point,
    output logic                               o_strobe,
    output pbd_pkg::t_result                   o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pbd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pbd_pkg::COORD_BITS-1:0]     i_cfg_data
);

    logic          push, full, pop_valid;
    pbd_pkg::t_job push_job, pop_job;

    pbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    pbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .o_full      (full),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_job)
    );

    pbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop_valid),
        .i_job    (pop_job),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

>>> rtl/pbd_front.sv
// ----------------------------------------------------------------------------
// pbd_front
// Holds the box configuration, takes query points, finds the axis gaps and
// the class flags, and pushes one job per item into the queue.
// ----------------------------------------------------------------------------
module pbd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pbd_pkg::t_point                      i_point,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pbd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [pbd_pkg::COORD_BITS-1:0]       i_cfg_data,
    input  logic                                 i_full,
    output logic                                 o_push,
    output pbd_pkg::t_job                        o_job
);

    localparam int CB     = pbd_pkg::COORD_BITS;
    localparam int MSB    = CB - 1;
    localparam int NEAR_W = CB + 2;

    pbd_pkg::t_coord r_left, r_bottom, r_right, r_top;
    logic [pbd_pkg::MARGIN_BITS-1:0] r_margin;

    logic signed [NEAR_W-1:0] r_near_left, r_near_bottom, r_near_right, r_near_top;
    logic signed [NEAR_W-1:0] n_near_left, n_near_bottom, n_near_right, n_near_top;
    logic r_box_ok, n_box_ok;

    logic            r_valid, n_valid;
    pbd_pkg::t_point r_pt;
    logic            accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= pbd_pkg::BOX_MIN_RESET;
            r_bottom <= pbd_pkg::BOX_MIN_RESET;
            r_right  <= pbd_pkg::BOX_MAX_RESET;
            r_top    <= pbd_pkg::BOX_MAX_RESET;
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbd_pkg::REG_BOX_LEFT:   r_left   <= i_cfg_data;
                pbd_pkg::REG_BOX_BOTTOM: r_bottom <= i_cfg_data;
                pbd_pkg::REG_BOX_RIGHT:  r_right  <= i_cfg_data;
                pbd_pkg::REG_BOX_TOP:    r_top    <= i_cfg_data;
                pbd_pkg::REG_MARGIN:     r_margin <= i_cfg_data[pbd_pkg::MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // grown box and validity are registered, so they follow the box registers in the next cycle
    always_comb begin
        n_near_left   = {{2{r_left[MSB]}}, r_left} - NEAR_W'(r_margin);
        n_near_bottom = {{2{r_bottom[MSB]}}, r_bottom} - NEAR_W'(r_margin);
        n_near_right  = {{2{r_right[MSB]}}, r_right} + NEAR_W'(r_margin);
        n_near_top    = {{2{r_top[MSB]}}, r_top} + NEAR_W'(r_margin);
        n_box_ok      = (r_left <= r_right) && (r_bottom <= r_top);
    end

    always_ff @(posedge i_clk) begin
        r_near_left   <= n_near_left;
        r_near_bottom <= n_near_bottom;
        r_near_right  <= n_near_right;
        r_near_top    <= n_near_top;
        r_box_ok      <= n_box_ok;
    end

    // hold the point while the queue is full
    assign busy   = r_valid && i_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pt <= i_point;
        end
    end

    pbd_pkg::t_coord x, y;
    logic signed [NEAR_W-1:0] x_w, y_w;
    logic [CB:0] dx_l, dx_r, dy_b, dy_t;
    logic x_le_l, x_ge_r, y_le_b, y_ge_t, x_br, y_br;
    logic on_in, strict_in, near;

    always_comb begin
        x      = r_pt.point_x;
        y      = r_pt.point_y;
        x_w    = {{2{x[MSB]}}, x};
        y_w    = {{2{y[MSB]}}, y};
        x_le_l = x <= r_left;
        x_ge_r = x >= r_right;
        y_le_b = y <= r_bottom;
        y_ge_t = y >= r_top;
        x_br   = x_le_l || x_ge_r;
        y_br   = y_le_b || y_ge_t;

        // gaps are non-negative wherever they are selected
        dx_l = {r_left[MSB], r_left} - {x[MSB], x};
        dx_r = {x[MSB], x} - {r_right[MSB], r_right};
        dy_b = {r_bottom[MSB], r_bottom} - {y[MSB], y};
        dy_t = {y[MSB], y} - {r_top[MSB], r_top};

        on_in     = (x >= r_left) && (x <= r_right) && (y >= r_bottom) && (y <= r_top);
        strict_in = (x > r_left) && (x < r_right) && (y > r_bottom) && (y < r_top);
        near      = (x_w >= r_near_left) && (x_w <= r_near_right) &&
                    (y_w >= r_near_bottom) && (y_w <= r_near_top);

        // a zero gap on an axis in span makes one hypotenuse cover all regions
        o_job.gap_x = !x_br ? '0 : (x_le_l ? dx_l[CB-1:0] : dx_r[CB-1:0]);
        o_job.gap_y = !y_br ? '0 : (y_le_b ? dy_b[CB-1:0] : dy_t[CB-1:0]);
        o_job.side.on_in = on_in;
        o_job.side.near  = near;
        if (!r_box_ok) begin
            o_job.side.cls = pbd_pkg::CLS_INDET;
        end else if (!on_in) begin
            o_job.side.cls = pbd_pkg::CLS_OUTSIDE;
        end else if (strict_in) begin
            o_job.side.cls = pbd_pkg::CLS_INSIDE;
        end else begin
            o_job.side.cls = pbd_pkg::CLS_EDGE;
        end
    end

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted item not held in front");

endmodule

>>> rtl/pbd_queue.sv
// ----------------------------------------------------------------------------
// pbd_queue
// Short job queue between front and back; the back drains one job a cycle.
// ----------------------------------------------------------------------------
module pbd_queue #(
    parameter int DEPTH = pbd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbd_pkg::t_job i_push_data,
    output logic          o_full,
    output logic          o_pop_valid,
    output pbd_pkg::t_job o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pbd_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic pop;

    assign o_full      = r_count == CNT_W'(DEPTH);
    assign o_pop_valid = r_count != '0;
    assign pop         = o_pop_valid;
    assign o_pop_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

>>> rtl/pbd_back.sv
// ----------------------------------------------------------------------------
// pbd_back
// Squares the gaps, takes a pipelined integer square root of their sum, one
// root bit per stage, and registers the result with its flags.
// ----------------------------------------------------------------------------
module pbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pbd_pkg::t_job    i_job,
    output logic             o_strobe,
    output pbd_pkg::t_result o_result
);

    localparam int CB    = pbd_pkg::COORD_BITS;
    localparam int GB    = pbd_pkg::GAP_BITS;
    localparam int RB    = CB + 1;
    localparam int RAD_W = 2 * RB;
    localparam int REM_W = RB + 2;
    localparam int SQ_W  = 2 * CB;
    localparam int WB    = (RB > GB) ? RB : GB;
    localparam logic [WB-1:0] GAP_MAX = WB'({GB{1'b1}});

    logic                r_sq_vld;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y;
    pbd_pkg::t_side      r_sq_side;

    logic                r_vld  [RB+1];
    logic [RAD_W-1:0]    r_rad  [RB+1];
    logic [REM_W-1:0]    r_rem  [RB+1];
    logic [RB-1:0]       r_root [RB+1];
    pbd_pkg::t_side      r_side [RB+1];

    logic                r_strobe;
    pbd_pkg::t_result    r_result;
    logic [WB-1:0]       root_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_sq_vld <= i_valid;
            r_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_x    <= i_job.gap_x * i_job.gap_x;
        r_sq_y    <= i_job.gap_y * i_job.gap_y;
        r_sq_side <= i_job.side;
        r_rad[0]  <= RAD_W'(r_sq_x) + RAD_W'(r_sq_y);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= r_sq_side;
    end

    for (genvar s = 0; s < RB; s++) begin : g_root
        logic [REM_W-1:0] t_rem, trial, n_rem;
        logic             ge;

        always_comb begin
            t_rem = {r_rem[s][REM_W-3:0], r_rad[s][RAD_W-1 -: 2]};
            trial = {r_root[s], 2'b01};
            ge    = t_rem >= trial;
            n_rem = ge ? t_rem - trial : t_rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[s+1]  <= r_rad[s] << 2;
            r_rem[s+1]  <= n_rem;
            r_root[s+1] <= {r_root[s][RB-2:0], ge};
            r_side[s+1] <= r_side[s];
        end
    end

    // saturate when the root outgrows the result field
    assign root_w = WB'(r_root[RB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.gap_length   <= (root_w > GAP_MAX) ? {GB{1'b1}} : root_w[GB-1:0];
        r_result.point_class  <= r_side[RB].cls;
        r_result.on_or_inside <= r_side[RB].on_in;
        r_result.near_box     <= r_side[RB].near;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.on_or_inside) |-> (o_result.gap_length == '0))
        else $error("nonzero distance for point on or inside box");

    a_class_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.point_class == pbd_pkg::CLS_INSIDE ||
                      o_result.point_class == pbd_pkg::CLS_EDGE))
        |-> o_result.on_or_inside)
        else $error("class and on-or-inside flag disagree");

    a_near_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.on_or_inside) |-> o_result.near_box)
        else $error("point in box but not near grown box");

endmodule
